>>> hdl/sxfb_pkg.sv
// Shared types and constants for the sprite XOR framebuffer.
package sxfb_pkg;

    localparam int SPRITE_BITS  = 8;
    localparam int ROW_PIXELS_W = 64;
    localparam int POS_W        = 8;
    localparam int OFFSET_W     = 4;
    localparam int POS_VALUES   = 1 << POS_W;
    localparam int OFFSET_VALUES = 1 << OFFSET_W;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_DRAW  = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t                   cmd;
        logic                   new_sprite;
        logic                   last;
        logic [SPRITE_BITS-1:0] bits;
    } s1_ctrl_t;

endpackage

>>> hdl/sxfb_ram.sv
// Framebuffer row memory: one write port, one read port, registered read data.
module sxfb_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64,
    parameter int AW    = 5
) (
    input  logic             aclk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/sxfb_draw.sv
// Sprite row XOR: builds the wrapped pixel mask and flags lit pixels turned off.
module sxfb_draw #(
    parameter int WIDTH = 64,
    parameter int CW    = 6
) (
    input  logic [WIDTH-1:0]                   word_in,
    input  logic [sxfb_pkg::SPRITE_BITS-1:0]   bits,
    input  logic [CW-1:0]                      x_mod,
    output logic [WIDTH-1:0]                   word_out,
    output logic                               hit
);

    logic [WIDTH-1:0] mask;

    always_comb begin
        logic [CW:0] c;
        mask = '0;
        for (int col = 0; col < sxfb_pkg::SPRITE_BITS; col++) begin
            c = {1'b0, x_mod} + (CW+1)'(col);
            if (c >= (CW+1)'(WIDTH)) begin
                c = c - (CW+1)'(WIDTH);
            end
            if (bits[sxfb_pkg::SPRITE_BITS-1-col]) begin
                mask[(WIDTH-1) - int'(c)] = 1'b1;
            end
        end
    end

    assign hit      = |(word_in & mask);
    assign word_out = word_in ^ mask;

endmodule

>>> hdl/sprite_xor_framebuffer_top.sv
// Sprite XOR framebuffer: top level with the read-modify-write pipeline.
//
// Input items arrive on s_tvalid/s_tready. s_tuser carries the command
// (clear, draw row, read row); s_tdata carries x, y, row offset and the eight
// sprite pixels; s_tlast marks the final row of a sprite. Every item gives
// exactly one result item on m_tvalid/m_tready: m_tdata holds the running
// collision flag and, for a read, the 64-pixel row (bit 63 is column 0);
// m_tlast is set for the last row of a drawn sprite.
// The row memory is read at the edge that accepts an item; XOR, write-back and
// the result register follow in stage 1, which raises m_tvalid. Without
// back-pressure one item is taken every cycle; a write to the row that the
// following item reads is forwarded. A clear resets the per-row valid flags.
// When the receiver stalls, the result register holds, the stage behind it
// holds its memory data and s_tready drops once that stage holds an item.
// After reset all pixels read as off and the collision flag is zero; no
// clearing pass is needed, so items are taken from the first cycle.
module sprite_xor_framebuffer_top #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // x_pos[7:0], y_pos[15:8], row_offset[19:16], sprite_bits[27:20]
    input  logic [1:0]  s_tuser,  // command[1:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // collision[0], row_pixels[64:1]
    output logic        m_tlast
);

    localparam int CW = $clog2(SCREEN_WIDTH);
    localparam int RW = $clog2(SCREEN_HEIGHT);
    localparam int PW = sxfb_pkg::ROW_PIXELS_W;

    // input fields
    logic [sxfb_pkg::POS_W-1:0]       in_x;
    logic [sxfb_pkg::POS_W-1:0]       in_y;
    logic [sxfb_pkg::OFFSET_W-1:0]    in_offset;
    logic [sxfb_pkg::SPRITE_BITS-1:0] in_bits;
    sxfb_pkg::cmd_t                   in_cmd;

    assign in_x      = s_tdata[7:0];
    assign in_y      = s_tdata[15:8];
    assign in_offset = s_tdata[19:16];
    assign in_bits   = s_tdata[27:20];
    assign in_cmd    = sxfb_pkg::cmd_t'(s_tuser);

    // modulo tables
    logic [CW-1:0] xmod_tab [sxfb_pkg::POS_VALUES];
    logic [RW-1:0] ymod_tab [sxfb_pkg::POS_VALUES];
    logic [RW-1:0] omod_tab [sxfb_pkg::OFFSET_VALUES];

    for (genvar i = 0; i < sxfb_pkg::POS_VALUES; i++) begin : g_pos_tab
        localparam logic [CW-1:0] XM = CW'(i % SCREEN_WIDTH);
        localparam logic [RW-1:0] YM = RW'(i % SCREEN_HEIGHT);
        assign xmod_tab[i] = XM;
        assign ymod_tab[i] = YM;
    end

    for (genvar i = 0; i < sxfb_pkg::OFFSET_VALUES; i++) begin : g_off_tab
        localparam logic [RW-1:0] OM = RW'(i % SCREEN_HEIGHT);
        assign omod_tab[i] = OM;
    end

    // stage 0: address decode
    logic [RW-1:0] y_mod;
    logic [RW:0]   row_sum;
    logic [RW-1:0] draw_row;
    logic [RW-1:0] rd_row;
    logic          s_accept;

    assign y_mod   = ymod_tab[in_y];
    assign row_sum = {1'b0, y_mod} + {1'b0, omod_tab[in_offset]};

    always_comb begin
        if (row_sum >= (RW+1)'(SCREEN_HEIGHT)) begin
            draw_row = RW'(row_sum - (RW+1)'(SCREEN_HEIGHT));
        end else begin
            draw_row = RW'(row_sum);
        end
    end

    assign rd_row = (in_cmd == sxfb_pkg::CMD_DRAW) ? draw_row : y_mod;

    // stage 1 registers
    logic                  s1_valid_reg, s1_valid_next;
    sxfb_pkg::s1_ctrl_t    s1_ctrl_reg;
    logic [CW-1:0]         s1_xm_reg;
    logic [RW-1:0]         s1_row_reg;
    logic                  s1_done;

    // framebuffer state
    logic [SCREEN_HEIGHT-1:0] row_valid_reg, row_valid_next;
    logic                     coll_reg, coll_next;
    logic                     fwd_valid_reg, fwd_valid_next;
    logic [RW-1:0]            fwd_row_reg;
    logic [SCREEN_WIDTH-1:0]  fwd_word_reg;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic          m_coll_reg;
    logic [PW-1:0] m_pixels_reg;
    logic          m_last_reg;

    logic [SCREEN_WIDTH-1:0] mem_q;
    logic [SCREEN_WIDTH-1:0] cur_word;
    logic [SCREEN_WIDTH-1:0] new_word;
    logic                    draw_hit;
    logic                    wr_en;

    assign s1_done  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_done;
    assign s_accept = s_tvalid && s_tready;

    sxfb_ram #(
        .DEPTH (SCREEN_HEIGHT),
        .WIDTH (SCREEN_WIDTH),
        .AW    (RW)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (rd_row),
        .rd_data (mem_q),
        .wr_en   (wr_en),
        .wr_addr (s1_row_reg),
        .wr_data (new_word)
    );

    always_comb begin
        if (fwd_valid_reg && fwd_row_reg == s1_row_reg) begin
            cur_word = fwd_word_reg;
        end else if (row_valid_reg[s1_row_reg]) begin
            cur_word = mem_q;
        end else begin
            cur_word = '0;
        end
    end

    sxfb_draw #(
        .WIDTH (SCREEN_WIDTH),
        .CW    (CW)
    ) u_draw (
        .word_in  (cur_word),
        .bits     (s1_ctrl_reg.bits),
        .x_mod    (s1_xm_reg),
        .word_out (new_word),
        .hit      (draw_hit)
    );

    assign wr_en = s1_done && (s1_ctrl_reg.cmd == sxfb_pkg::CMD_DRAW);

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        row_valid_next = row_valid_reg;
        coll_next      = coll_reg;
        fwd_valid_next = fwd_valid_reg;
        m_valid_next   = m_valid_reg;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s1_done) begin
            s1_valid_next  = 1'b0;
            m_valid_next   = 1'b1;
            fwd_valid_next = 1'b0;
            case (s1_ctrl_reg.cmd)
                sxfb_pkg::CMD_CLEAR: begin
                    row_valid_next = '0;
                end
                sxfb_pkg::CMD_DRAW: begin
                    row_valid_next[s1_row_reg] = 1'b1;
                    coll_next      = (coll_reg && !s1_ctrl_reg.new_sprite) || draw_hit;
                    fwd_valid_next = 1'b1;
                end
                default: begin
                end
            endcase
        end
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
            coll_reg      <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            row_valid_reg <= row_valid_next;
            coll_reg      <= coll_next;
            fwd_valid_reg <= fwd_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ctrl_reg.cmd        <= in_cmd;
            s1_ctrl_reg.new_sprite <= (in_offset == '0);
            s1_ctrl_reg.last       <= s_tlast;
            s1_ctrl_reg.bits       <= in_bits;
            s1_xm_reg              <= xmod_tab[in_x];
            s1_row_reg             <= rd_row;
        end
        if (wr_en) begin
            fwd_row_reg  <= s1_row_reg;
            fwd_word_reg <= new_word;
        end
        if (s1_done) begin
            m_coll_reg <= coll_next;
            m_last_reg <= (s1_ctrl_reg.cmd == sxfb_pkg::CMD_DRAW) && s1_ctrl_reg.last;
            if (s1_ctrl_reg.cmd == sxfb_pkg::CMD_READ) begin
                m_pixels_reg <= PW'(cur_word) << (PW - SCREEN_WIDTH);
            end else begin
                m_pixels_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_pixels_reg, m_coll_reg};
    assign m_tlast  = m_last_reg;

endmodule
